### design/wcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared constants, types and control structs of the correlation statistics
// block.
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int WINDOW          = 7;
    localparam int SAMPLE_BITS     = 12;
    localparam int MAX_TILE_PIXELS = 65536;
    localparam int IN_ROWS         = 7;

    localparam int TAPS       = WINDOW * WINDOW;
    localparam int HALF       = WINDOW / 2;
    localparam int CENTRE_TAP = HALF * WINDOW + HALF;

    localparam int ADDR_W = $clog2(TAPS + 1);
    localparam int IDX_W  = 6;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int CNT_W  = 17;
    localparam int SUM_W  = 41;
    localparam int TAP_W  = 28;
    localparam int VAL_W  = 59;
    localparam int LO_W   = 21;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int DIF_W  = TAP_W + 2;
    localparam int MUL_W  = 31;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_COLUMN = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_ACC_TAIL,
        S_READ,
        S_RD_OUT
    } t_state;

    typedef struct packed {
        logic              issue;
        logic              cross_step;
        logic              first;
        logic              clr_wr;
        logic              clr_regs;
        logic [ADDR_W-1:0] addr;
    } t_lane_ctrl;

endpackage
`default_nettype wire

### design/wcs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_lane
// One tap lane: multiplier, pair-sum memory column, tap and cross sums.
// ----------------------------------------------------------------------------
module wcs_lane (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire wcs_pkg::t_lane_ctrl               i_ctrl,
    input  wire logic [wcs_pkg::SAMPLE_BITS-1:0]   i_operand,
    input  wire logic [wcs_pkg::SAMPLE_BITS-1:0]   i_tap,
    output logic      [wcs_pkg::SUM_W-1:0]         o_rdata,
    output logic      [wcs_pkg::TAP_W-1:0]         o_tap_sum,
    output logic      [wcs_pkg::SUM_W-1:0]         o_cross_sum
);

    logic [wcs_pkg::SUM_W-1:0]  r_mem [wcs_pkg::TAPS];
    logic [wcs_pkg::SUM_W-1:0]  r_rdata;
    logic [wcs_pkg::PROD_W-1:0] r_prod;
    logic [wcs_pkg::ADDR_W-1:0] r_wr_addr;
    logic                       r_wr_en;
    logic                       r_cr_en;
    logic [wcs_pkg::TAP_W-1:0]  r_tap_sum;
    logic [wcs_pkg::SUM_W-1:0]  r_cross_sum;
    logic [wcs_pkg::SUM_W-1:0]  n_wdata;

    assign n_wdata = r_rdata + {{(wcs_pkg::SUM_W-wcs_pkg::PROD_W){1'b0}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
            r_cr_en <= 1'b0;
        end else begin
            r_wr_en <= i_ctrl.issue && !i_ctrl.cross_step;
            r_cr_en <= i_ctrl.issue && i_ctrl.cross_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod    <= i_operand * i_tap;
            r_wr_addr <= i_ctrl.addr;
        end
    end

    // pair-sum column: read-modify-write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= n_wdata;
        end else if (i_ctrl.clr_wr) begin
            r_mem[i_ctrl.addr] <= '0;
        end
        r_rdata <= r_mem[i_ctrl.addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_regs) begin
            r_tap_sum   <= '0;
            r_cross_sum <= '0;
        end else begin
            if (i_ctrl.issue && i_ctrl.first) begin
                r_tap_sum <= r_tap_sum
                    + {{(wcs_pkg::TAP_W-wcs_pkg::SAMPLE_BITS){1'b0}}, i_tap};
            end
            if (r_cr_en) begin
                r_cross_sum <= r_cross_sum
                    + {{(wcs_pkg::SUM_W-wcs_pkg::PROD_W){1'b0}}, r_prod};
            end
        end
    end

    assign o_rdata     = r_rdata;
    assign o_tap_sum   = r_tap_sum;
    assign o_cross_sum = r_cross_sum;

endmodule
`default_nettype wire

### design/wcs_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_merge
// Read unit: selects lane results and forms the centred, count-scaled entry
// with one shared multiplier over five phases.
// ----------------------------------------------------------------------------
module wcs_merge (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [wcs_pkg::ADDR_W-1:0]     i_row,
    input  wire logic [wcs_pkg::ADDR_W-1:0]     i_col,
    input  wire logic                           i_cross,
    input  wire logic                           i_bad,
    input  wire logic [wcs_pkg::SUM_W-1:0]      i_rdata [wcs_pkg::TAPS],
    input  wire logic [wcs_pkg::TAP_W-1:0]      i_tap_sum [wcs_pkg::TAPS],
    input  wire logic [wcs_pkg::SUM_W-1:0]      i_cross_sum [wcs_pkg::TAPS],
    input  wire logic [wcs_pkg::TAP_W-1:0]      i_src_sum,
    input  wire logic [wcs_pkg::CNT_W-1:0]      i_count,
    output logic                                o_busy,
    output logic      [wcs_pkg::VAL_W-1:0]      o_value
);

    logic [2:0]                        r_ph;
    logic [wcs_pkg::ADDR_W-1:0]        r_row;
    logic [wcs_pkg::ADDR_W-1:0]        r_col;
    logic                              r_cross;
    logic                              r_bad;
    logic [wcs_pkg::SUM_W-1:0]         r_p;
    logic [wcs_pkg::TAP_W-1:0]         r_a;
    logic [wcs_pkg::TAP_W-1:0]         r_b;
    logic signed [wcs_pkg::DIF_W-1:0]  r_d;
    logic signed [2*wcs_pkg::MUL_W-1:0] r_m;
    logic [wcs_pkg::VAL_W-1:0]         r_acc;
    logic [wcs_pkg::VAL_W-1:0]         r_val;
    logic signed [wcs_pkg::MUL_W-1:0]  mul_a;
    logic signed [wcs_pkg::MUL_W-1:0]  mul_b;
    logic [wcs_pkg::TAP_W-1:0]         s_sum;

    assign s_sum = i_tap_sum[wcs_pkg::CENTRE_TAP];

    always_comb begin
        mul_a = $signed({{(wcs_pkg::MUL_W-wcs_pkg::CNT_W){1'b0}}, i_count});
        mul_b = $signed({{(wcs_pkg::MUL_W-wcs_pkg::LO_W){1'b0}},
                         r_p[wcs_pkg::LO_W-1:0]});
        case (r_ph)
            3'd3: begin
                mul_b = $signed({{(wcs_pkg::MUL_W-wcs_pkg::HI_W){1'b0}},
                                 r_p[wcs_pkg::SUM_W-1:wcs_pkg::LO_W]});
            end
            3'd4: begin
                mul_a = $signed({{(wcs_pkg::MUL_W-wcs_pkg::TAP_W){1'b0}}, s_sum});
                mul_b = {{(wcs_pkg::MUL_W-wcs_pkg::DIF_W){r_d[wcs_pkg::DIF_W-1]}}, r_d};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 3'd0;
        end else if (i_start) begin
            r_ph <= 3'd1;
        end else if (r_ph == 3'd5) begin
            r_ph <= 3'd0;
        end else if (r_ph != 3'd0) begin
            r_ph <= r_ph + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_row   <= i_row;
            r_col   <= i_col;
            r_cross <= i_cross;
            r_bad   <= i_bad;
        end
        case (r_ph)
            3'd1: begin
                r_p <= r_cross ? i_cross_sum[r_row] : i_rdata[r_col];
                r_a <= i_tap_sum[r_row];
                r_b <= r_cross ? i_src_sum : i_tap_sum[r_col];
            end
            3'd2: begin
                r_d <= $signed({2'b00, r_a}) + $signed({2'b00, r_b})
                       - $signed({2'b00, s_sum});
                r_m <= mul_a * mul_b;
            end
            3'd3: begin
                r_acc <= r_m[wcs_pkg::VAL_W-1:0];
                r_m   <= mul_a * mul_b;
            end
            3'd4: begin
                r_acc <= r_acc + {r_m[wcs_pkg::VAL_W-wcs_pkg::LO_W-1:0],
                                  {wcs_pkg::LO_W{1'b0}}};
                r_m   <= mul_a * mul_b;
            end
            3'd5: begin
                r_val <= r_bad ? '0 : r_acc - r_m[wcs_pkg::VAL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_busy  = (r_ph != 3'd0);
    assign o_value = r_val;

endmodule
`default_nettype wire

### design/wiener_correlation_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wiener_correlation_stats
// Wiener restoration statistics for one tile over a 7x7 shifting window.
// ----------------------------------------------------------------------------
// Usage: one item is in flight at a time and o_in_ready is high only while the
// block is idle. A column transfer that does not accumulate (window not
// complete, or the tile already holds the maximum pixel count) leaves the
// block idle. A complete window runs 50 issue steps of the 49 lane
// multipliers (one tap row of the pair matrix per step, then the cross step
// against the source sample) plus a drain state and the return to idle; the
// pair-sum memory read-modify-write paces this. A clear sweeps all lane
// memories, one row per cycle, and the same sweep runs right after reset
// before the first transfer is taken. A read runs a memory read, the lane
// selection and three passes through one shared multiplier, and its result
// waits in the output register until taken. Samples are used as 12-bit
// values; the matrix is kept symmetric in full, so entry (k,l) equals entry
// (l,k).
// ----------------------------------------------------------------------------
module wiener_correlation_stats (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [1:0]                       i_action,
    input  wire logic [11:0]                      i_dgd_up3,
    input  wire logic [11:0]                      i_dgd_up2,
    input  wire logic [11:0]                      i_dgd_up1,
    input  wire logic [11:0]                      i_dgd_mid,
    input  wire logic [11:0]                      i_dgd_down1,
    input  wire logic [11:0]                      i_dgd_down2,
    input  wire logic [11:0]                      i_dgd_down3,
    input  wire logic [11:0]                      i_src_pixel,
    input  wire logic                             i_window_complete,
    input  wire logic [5:0]                       i_entry_row,
    input  wire logic [5:0]                       i_entry_col,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [58:0]                      o_scaled_value,
    output logic      [16:0]                      o_pixel_count
);

    wcs_pkg::t_state                   r_state;
    wcs_pkg::t_state                   n_state;
    logic [wcs_pkg::ADDR_W-1:0]        r_step;
    logic [wcs_pkg::ADDR_W-1:0]        n_step;
    logic [wcs_pkg::SAMPLE_BITS-1:0]   r_win [wcs_pkg::TAPS];
    logic [wcs_pkg::SAMPLE_BITS-1:0]   n_win [wcs_pkg::TAPS];
    logic [wcs_pkg::SAMPLE_BITS-1:0]   r_x;
    logic [wcs_pkg::TAP_W-1:0]         r_src_sum;
    logic [wcs_pkg::CNT_W-1:0]         r_count;
    logic                              r_out_valid;
    logic [wcs_pkg::VAL_W-1:0]         r_out_value;
    logic [wcs_pkg::CNT_W-1:0]         r_out_count;

    logic [wcs_pkg::SAMPLE_BITS-1:0]   in_col [wcs_pkg::IN_ROWS];
    logic                              in_xfer;
    logic                              acc_go;
    logic                              rd_row_ok;
    logic                              rd_bad;
    logic                              rd_cross;
    logic [wcs_pkg::ADDR_W-1:0]        rd_row;
    logic [wcs_pkg::ADDR_W-1:0]        rd_col;
    wcs_pkg::t_lane_ctrl               ctrl;
    logic [wcs_pkg::SAMPLE_BITS-1:0]   operand;
    logic                              rd_start;
    logic                              load_out;

    logic [wcs_pkg::SUM_W-1:0]         lane_rdata [wcs_pkg::TAPS];
    logic [wcs_pkg::TAP_W-1:0]         lane_tap [wcs_pkg::TAPS];
    logic [wcs_pkg::SUM_W-1:0]         lane_cross [wcs_pkg::TAPS];
    logic                              mrg_busy;
    logic [wcs_pkg::VAL_W-1:0]         mrg_value;

    assign in_col[0] = i_dgd_up3;
    assign in_col[1] = i_dgd_up2;
    assign in_col[2] = i_dgd_up1;
    assign in_col[3] = i_dgd_mid;
    assign in_col[4] = i_dgd_down1;
    assign in_col[5] = i_dgd_down2;
    assign in_col[6] = i_dgd_down3;

    assign in_xfer = i_in_valid && o_in_ready;
    assign acc_go  = i_window_complete
                     && (r_count < wcs_pkg::CNT_W'(wcs_pkg::MAX_TILE_PIXELS));

    // Read index checks; out-of-range indexes read lane 0 and are zeroed later.
    assign rd_row_ok = (i_entry_row < wcs_pkg::IDX_W'(wcs_pkg::TAPS));
    assign rd_bad    = !rd_row_ok || (i_entry_col > wcs_pkg::IDX_W'(wcs_pkg::TAPS));
    assign rd_cross  = (i_entry_col == wcs_pkg::IDX_W'(wcs_pkg::TAPS));
    assign rd_row    = rd_bad ? '0 : i_entry_row[wcs_pkg::ADDR_W-1:0];
    assign rd_col    = (rd_bad || rd_cross) ? '0 : i_entry_col[wcs_pkg::ADDR_W-1:0];

    // Shift the window left; the newest column enters on the right.
    always_comb begin
        int off;
        for (int t = 0; t < wcs_pkg::TAPS - wcs_pkg::WINDOW; t++) begin
            n_win[t] = r_win[t + wcs_pkg::WINDOW];
        end
        for (int r = 0; r < wcs_pkg::WINDOW; r++) begin
            off = r - wcs_pkg::HALF + wcs_pkg::IN_ROWS / 2;
            if (off >= 0 && off < wcs_pkg::IN_ROWS) begin
                n_win[wcs_pkg::TAPS - wcs_pkg::WINDOW + r] = in_col[off];
            end else begin
                n_win[wcs_pkg::TAPS - wcs_pkg::WINDOW + r] = '0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            wcs_pkg::S_CLEAR: begin
                n_step = r_step + wcs_pkg::ADDR_W'(1);
                if (r_step == wcs_pkg::ADDR_W'(wcs_pkg::TAPS - 1)) begin
                    n_state = wcs_pkg::S_IDLE;
                    n_step  = '0;
                end
            end
            wcs_pkg::S_IDLE: begin
                n_step = '0;
                if (in_xfer) begin
                    case (i_action)
                        wcs_pkg::ACT_CLEAR:  n_state = wcs_pkg::S_CLEAR;
                        wcs_pkg::ACT_COLUMN: begin
                            if (acc_go) begin
                                n_state = wcs_pkg::S_ACC;
                            end
                        end
                        wcs_pkg::ACT_READ:   n_state = wcs_pkg::S_READ;
                        default:             n_state = wcs_pkg::S_IDLE;
                    endcase
                end
            end
            wcs_pkg::S_ACC: begin
                n_step = r_step + wcs_pkg::ADDR_W'(1);
                if (r_step == wcs_pkg::ADDR_W'(wcs_pkg::TAPS)) begin
                    n_state = wcs_pkg::S_ACC_TAIL;
                end
            end
            wcs_pkg::S_ACC_TAIL: n_state = wcs_pkg::S_IDLE;
            wcs_pkg::S_READ: begin
                if (!mrg_busy) begin
                    n_state = wcs_pkg::S_RD_OUT;
                end
            end
            wcs_pkg::S_RD_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = wcs_pkg::S_IDLE;
                end
            end
            default: n_state = wcs_pkg::S_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ctrl       = '0;
        operand    = '0;
        rd_start   = 1'b0;
        load_out   = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            wcs_pkg::S_CLEAR: begin
                ctrl.clr_wr   = 1'b1;
                ctrl.clr_regs = 1'b1;
                ctrl.addr     = r_step;
            end
            wcs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                ctrl.addr  = rd_row;
                rd_start   = in_xfer && (i_action == wcs_pkg::ACT_READ);
            end
            wcs_pkg::S_ACC: begin
                ctrl.issue = 1'b1;
                ctrl.first = (r_step == '0);
                if (r_step == wcs_pkg::ADDR_W'(wcs_pkg::TAPS)) begin
                    ctrl.cross_step = 1'b1;
                    operand         = r_x;
                end else begin
                    ctrl.addr = r_step;
                    operand   = r_win[r_step];
                end
            end
            wcs_pkg::S_RD_OUT: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wcs_pkg::S_CLEAR;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < wcs_pkg::TAPS; t++) begin
                r_win[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer && i_action == wcs_pkg::ACT_COLUMN) begin
                r_win <= n_win;
            end
        end
    end

    // tile totals: clear in the sweep, advance at the start of an accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == wcs_pkg::S_CLEAR) begin
            r_src_sum <= '0;
            r_count   <= '0;
        end else if (in_xfer && i_action == wcs_pkg::ACT_COLUMN && acc_go) begin
            r_x       <= i_src_pixel;
            r_src_sum <= r_src_sum
                + {{(wcs_pkg::TAP_W-wcs_pkg::SAMPLE_BITS){1'b0}}, i_src_pixel};
            r_count   <= r_count + wcs_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= mrg_value;
            r_out_count <= r_count;
        end
    end

    for (genvar l = 0; l < wcs_pkg::TAPS; l++) begin : g_lane
        wcs_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_operand   (operand),
            .i_tap       (r_win[l]),
            .o_rdata     (lane_rdata[l]),
            .o_tap_sum   (lane_tap[l]),
            .o_cross_sum (lane_cross[l])
        );
    end

    wcs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (rd_start),
        .i_row       (rd_row),
        .i_col       (rd_col),
        .i_cross     (rd_cross),
        .i_bad       (rd_bad),
        .i_rdata     (lane_rdata),
        .i_tap_sum   (lane_tap),
        .i_cross_sum (lane_cross),
        .i_src_sum   (r_src_sum),
        .i_count     (r_count),
        .o_busy      (mrg_busy),
        .o_value     (mrg_value)
    );

    assign o_out_valid    = r_out_valid;
    assign o_scaled_value = r_out_value;
    assign o_pixel_count  = r_out_count;

    // A read transfer always leaves the idle state.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == wcs_pkg::ACT_READ) |=> !o_in_ready)
        else $error("read transfer did not make the block busy");

    // The pixel count never passes the tile limit.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wcs_pkg::CNT_W'(wcs_pkg::MAX_TILE_PIXELS))
        else $error("pixel count beyond tile limit");

    // Accumulation and the clearing sweep never drive the lanes together.
    a_lane_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.issue && ctrl.clr_wr))
        else $error("lane accumulate and clear at once");

    // A result appears only after the read unit has finished.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == wcs_pkg::S_RD_OUT && !mrg_busy))
        else $error("result without a finished read");

endmodule
`default_nettype wire
